/* src/pfgb_pkg.sv */
// ----------------------------------------------------------------------------
// pfgb_pkg
// Shared constants, codes and types of the planar font glyph blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfgb_pkg;

    localparam int GLYPH_COUNT    = 96;
    localparam int BYTES_PER_LINE = 80;
    localparam int SCREEN_HEIGHT  = 480;
    localparam int SCREEN_WIDTH   = 640;

    localparam int FIRST_CODE  = 32;
    localparam int GLYPH_ROWS  = 8;
    localparam int GIDX_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FONT_AW     = GIDX_W + 3;
    localparam int FRAME_DEPTH = BYTES_PER_LINE * SCREEN_HEIGHT;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    // linear address reach of y*line + col + 7 lines, also for off screen rows
    localparam int ADDR_W      = $clog2((1024 + GLYPH_ROWS) * BYTES_PER_LINE);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int RES_W      = 38;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_DRAW = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CODE = 2'd1;
    localparam logic [1:0] ST_OFF  = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DRAW,
        OP_READ,
        OP_REJECT,
        OP_OFFSCREEN
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FONT,
        S_DRAW_RD,
        S_DRAW_WR,
        S_READ_RD,
        S_READ_DATA,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [GIDX_W-1:0]   gidx;
        logic [2:0]          grow;
        logic [7:0]          gbyte;
        logic [3:0]          color;
        logic [9:0]          y;
        logic                x_ok;
        logic [ADDR_W-1:0]   base;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  rows_clipped;
        logic [31:0] plane_bytes;
    } t_result;

endpackage

`default_nettype wire

/* src/pfgb_front.sv */
// ----------------------------------------------------------------------------
// pfgb_front
// Unpacks an incoming item, checks code and position, and queues a command.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgb_front (
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pfgb_pkg::IN_DATA_W-1:0]   i_data,
    input  logic [pfgb_pkg::IN_USER_W-1:0]   i_user,
    input  logic                             i_busy,
    input  pfgb_pkg::t_qstat                 i_qstat,
    output logic                             o_push,
    output pfgb_pkg::t_cmd                   o_cmd
);

    logic [9:0] x;
    logic [9:0] y;
    logic [3:0] color;
    logic [7:0] code;
    logic [2:0] grow;
    logic [7:0] gbyte;
    logic [7:0] idx;
    logic       code_ok;
    logic       x_ok;
    logic       y_ok;

    assign x     = i_data[9:0];
    assign y     = i_data[19:10];
    assign color = i_data[23:20];
    assign code  = i_data[31:24];
    assign grow  = i_data[34:32];
    assign gbyte = i_data[42:35];

    assign idx     = code - 8'(pfgb_pkg::FIRST_CODE);
    assign code_ok = (code >= 8'(pfgb_pkg::FIRST_CODE))
                     && ({1'b0, idx} < 9'(pfgb_pkg::GLYPH_COUNT));
    assign x_ok    = ({1'b0, x} <= 11'(pfgb_pkg::SCREEN_WIDTH - 1))
                     && ({2'b00, x[9:3]} < 9'(pfgb_pkg::BYTES_PER_LINE));
    assign y_ok    = ({1'b0, y} <= 11'(pfgb_pkg::SCREEN_HEIGHT - 1));

    assign o_ready = !i_qstat.full && !i_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.gidx  = idx[pfgb_pkg::GIDX_W-1:0];
        o_cmd.grow  = grow;
        o_cmd.gbyte = gbyte;
        o_cmd.color = color;
        o_cmd.y     = y;
        o_cmd.x_ok  = x_ok;
        o_cmd.base  = pfgb_pkg::ADDR_W'(y) * pfgb_pkg::ADDR_W'(pfgb_pkg::BYTES_PER_LINE)
                      + pfgb_pkg::ADDR_W'(x[9:3]);
        case (i_user)
            pfgb_pkg::MODE_LOAD: begin
                o_cmd.op = code_ok ? pfgb_pkg::OP_LOAD : pfgb_pkg::OP_REJECT;
            end
            pfgb_pkg::MODE_DRAW: begin
                o_cmd.op = code_ok ? pfgb_pkg::OP_DRAW : pfgb_pkg::OP_REJECT;
            end
            pfgb_pkg::MODE_READ: begin
                o_cmd.op = (x_ok && y_ok) ? pfgb_pkg::OP_READ : pfgb_pkg::OP_OFFSCREEN;
            end
            default: begin
                o_cmd.op = pfgb_pkg::OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/pfgb_queue.sv */
// ----------------------------------------------------------------------------
// pfgb_queue
// Short command FIFO between the front classifier and the back executor.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pfgb_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output pfgb_pkg::t_cmd   o_cmd,
    output pfgb_pkg::t_qstat o_qstat
);

    pfgb_pkg::t_cmd         r_mem [pfgb_pkg::QDEPTH];
    logic [pfgb_pkg::QAW:0] r_wr_ptr;
    logic [pfgb_pkg::QAW:0] r_rd_ptr;

    assign o_qstat.empty = (r_wr_ptr == r_rd_ptr);
    assign o_qstat.full  = (r_wr_ptr == {~r_rd_ptr[pfgb_pkg::QAW],
                                         r_rd_ptr[pfgb_pkg::QAW-1:0]});
    assign o_cmd = r_mem[r_rd_ptr[pfgb_pkg::QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[pfgb_pkg::QAW-1:0]] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* src/pfgb_back.sv */
// ----------------------------------------------------------------------------
// pfgb_back
// Executes queued commands against the font and frame memories and holds
// the result register. Clears the frame memory after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfgb_pkg::t_cmd    i_cmd,
    input  pfgb_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output pfgb_pkg::t_result o_result
);

    function automatic logic [31:0] paint(input logic [31:0] word,
                                          input logic [3:0]  color,
                                          input logic [7:0]  glyph);
        logic [31:0] res;
        res = '0;
        for (int p = 0; p < 4; p++) begin
            if (color[p]) begin
                res[8*p +: 8] = word[8*p +: 8] | ~glyph;
            end else begin
                res[8*p +: 8] = word[8*p +: 8] & glyph;
            end
        end
        return res;
    endfunction

    logic [7:0]  font_mem  [pfgb_pkg::FONT_DEPTH];
    logic [31:0] frame_mem [pfgb_pkg::FRAME_DEPTH];

    pfgb_pkg::t_state  r_state, n_state;
    logic [pfgb_pkg::FRAME_AW-1:0] r_clr_addr, n_clr_addr;
    pfgb_pkg::t_cmd    r_cmd, n_cmd;
    logic [2:0]        r_row, n_row;
    logic [pfgb_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic              r_row_ok, n_row_ok;
    logic [3:0]        r_clipped, n_clipped;
    pfgb_pkg::t_result r_res, n_res;
    logic              r_out_valid, n_out_valid;
    pfgb_pkg::t_result r_out, n_out;
    logic [7:0]        r_font_q;
    logic [31:0]       r_frame_q;

    logic                          font_we;
    logic                          font_re;
    logic [pfgb_pkg::FONT_AW-1:0]  font_addr;
    logic                          frame_we;
    logic                          frame_re;
    logic [pfgb_pkg::FRAME_AW-1:0] frame_addr;
    logic [31:0]                   frame_wd;
    logic [10:0]                   line;
    logic [3:0]                    clip_total;

    assign line       = 11'(r_cmd.y) + 11'(r_row);
    assign clip_total = r_clipped + {3'b000, ~r_row_ok};

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_row       = r_row;
        n_addr      = r_addr;
        n_row_ok    = r_row_ok;
        n_clipped   = r_clipped;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        font_we     = 1'b0;
        font_re     = 1'b0;
        font_addr   = {r_cmd.gidx, r_row};
        frame_we    = 1'b0;
        frame_re    = 1'b0;
        frame_addr  = r_addr[pfgb_pkg::FRAME_AW-1:0];
        frame_wd    = paint(r_frame_q, r_cmd.color, r_font_q);
        case (r_state)
            pfgb_pkg::S_CLEAR: begin
                frame_we   = 1'b1;
                frame_addr = r_clr_addr;
                frame_wd   = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == pfgb_pkg::FRAME_AW'(pfgb_pkg::FRAME_DEPTH - 1)) begin
                    n_state = pfgb_pkg::S_IDLE;
                end
            end
            pfgb_pkg::S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd;
                    n_row     = '0;
                    n_addr    = i_cmd.base;
                    n_clipped = '0;
                    n_res     = '0;
                    case (i_cmd.op)
                        pfgb_pkg::OP_LOAD:      n_state = pfgb_pkg::S_FONT;
                        pfgb_pkg::OP_DRAW:      n_state = pfgb_pkg::S_DRAW_RD;
                        pfgb_pkg::OP_READ:      n_state = pfgb_pkg::S_READ_RD;
                        pfgb_pkg::OP_REJECT: begin
                            n_res.status = pfgb_pkg::ST_CODE;
                            n_state      = pfgb_pkg::S_DONE;
                        end
                        pfgb_pkg::OP_OFFSCREEN: begin
                            n_res.status = pfgb_pkg::ST_OFF;
                            n_state      = pfgb_pkg::S_DONE;
                        end
                        default:                n_state = pfgb_pkg::S_DONE;
                    endcase
                end
            end
            pfgb_pkg::S_FONT: begin
                font_we   = 1'b1;
                font_addr = {r_cmd.gidx, r_cmd.grow};
                n_state   = pfgb_pkg::S_DONE;
            end
            pfgb_pkg::S_DRAW_RD: begin
                n_row_ok = r_cmd.x_ok && (line <= 11'(pfgb_pkg::SCREEN_HEIGHT - 1));
                font_re  = n_row_ok;
                frame_re = n_row_ok;
                n_state  = pfgb_pkg::S_DRAW_WR;
            end
            pfgb_pkg::S_DRAW_WR: begin
                frame_we  = r_row_ok;
                n_clipped = clip_total;
                n_addr    = r_addr + pfgb_pkg::ADDR_W'(pfgb_pkg::BYTES_PER_LINE);
                n_row     = r_row + 1'b1;
                if (r_row == 3'(pfgb_pkg::GLYPH_ROWS - 1)) begin
                    n_res.rows_clipped = clip_total;
                    n_res.status = (clip_total == 4'(pfgb_pkg::GLYPH_ROWS))
                                   ? pfgb_pkg::ST_OFF : pfgb_pkg::ST_OK;
                    n_state = pfgb_pkg::S_DONE;
                end else begin
                    n_state = pfgb_pkg::S_DRAW_RD;
                end
            end
            pfgb_pkg::S_READ_RD: begin
                frame_re = 1'b1;
                n_state  = pfgb_pkg::S_READ_DATA;
            end
            pfgb_pkg::S_READ_DATA: begin
                n_res.plane_bytes = r_frame_q;
                n_state           = pfgb_pkg::S_DONE;
            end
            pfgb_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = pfgb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfgb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfgb_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_row     <= n_row;
        r_addr    <= n_addr;
        r_row_ok  <= n_row_ok;
        r_clipped <= n_clipped;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (font_we) begin
            font_mem[font_addr] <= r_cmd.gbyte;
        end
        if (font_re) begin
            r_font_q <= font_mem[font_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            frame_mem[frame_addr] <= frame_wd;
        end
        if (frame_re) begin
            r_frame_q <= frame_mem[frame_addr];
        end
    end

    assign o_busy   = (r_state == pfgb_pkg::S_CLEAR);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == pfgb_pkg::S_IDLE)
        else $error("command taken outside idle");

    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.rows_clipped <= 4'(pfgb_pkg::GLYPH_ROWS))
        else $error("clipped row count out of range");

    a_code_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == pfgb_pkg::ST_CODE)
            |-> (r_out.plane_bytes == '0 && r_out.rows_clipped == '0))
        else $error("rejected code with nonzero payload");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == pfgb_pkg::S_CLEAR && !r_out_valid))
        else $error("reset did not start the clear sweep");

endmodule

`default_nettype wire

/* src/planar_font_glyph_blitter_top.sv */
// ----------------------------------------------------------------------------
// planar_font_glyph_blitter_top
// 8x8 glyph blitter into a four-plane 640x480 frame store, with font load
// and frame readback.
//
// Channel  Dir  Handshake                          Content
// s_axis   in   i_s_axis_tvalid / o_s_axis_tready  command (mode in tuser)
// m_axis   out  o_m_axis_tvalid / i_m_axis_tready  plane bytes, clip count, status
//
// After reset the frame store is cleared word by word; no transfer is
// taken during that sweep. A draw reads the frame word of each on-screen
// glyph row, then writes it back painted. A two-entry command queue keeps
// input transfers flowing while the result register waits on
// i_m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_font_glyph_blitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // x[9:0], y[19:10], color[23:20], char_code[31:24], glyph_row[34:32],
    // glyph_byte[42:35], zero fill
    input  logic [47:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // plane_bytes[31:0], rows_clipped[35:32], status[37:36], zero fill
    output logic [39:0] o_m_axis_tdata
);

    pfgb_pkg::t_cmd    push_cmd;
    pfgb_pkg::t_cmd    head_cmd;
    pfgb_pkg::t_qstat  qstat;
    pfgb_pkg::t_result result;
    logic              push;
    logic              pop;
    logic              busy;

    pfgb_front u_front (
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_user  (i_s_axis_tuser),
        .i_busy  (busy),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    pfgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    pfgb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_busy   (busy),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {2'b00, result};

endmodule

`default_nettype wire
